### sv/sis_pkg.sv
`default_nettype none

package sis_pkg;

  // Number of cells in the sorting chain.
  localparam int unsigned StoreDepth = 32;

  // One input request: a value and the end-of-set mark.
  typedef struct packed {
    logic signed [31:0] value;
    logic               last_value;
  } in_req_t;

  // One output request of the drained run.
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_of_run;
    logic               overflow;
  } out_req_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_SHIFT  = 2'd2
  } cell_mode_e;

  // Broadcast from the controller to all cells.
  typedef struct packed {
    cell_mode_e         mode;
    logic signed [31:0] value;
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
    logic               gt;
  } cell_link_t;

endpackage

`default_nettype wire

### sv/sis_cell.sv
`default_nettype none

module sis_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sis_pkg::cell_ctrl_t  ctrl_i,
  input  sis_pkg::cell_link_t  left_i,
  input  sis_pkg::cell_link_t  right_i,
  output sis_pkg::cell_link_t  link_o
);
  import sis_pkg::*;

  logic signed [31:0] value_q, value_d;
  logic               valid_q, valid_d;
  logic               gt;

  // The broadcast value belongs behind this entry when it is strictly greater.
  assign gt = valid_q && (ctrl_i.value > value_q);

  assign link_o.value = value_q;
  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;

  // Keep, take the new value, or take the neighbor's entry.
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (ctrl_i.mode)
      MODE_INSERT: begin
        if (gt) begin
          value_d = value_q;
          valid_d = valid_q;
        end else if (left_i.gt) begin
          value_d = ctrl_i.value;
          valid_d = 1'b1;
        end else begin
          value_d = left_i.value;
          valid_d = left_i.valid;
        end
      end
      MODE_SHIFT: begin
        value_d = right_i.value;
        valid_d = right_i.valid;
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  // Valid flag is control state; the value needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

### sv/sorted_insertion_store.sv
// A new value is accepted every cycle while filling. A request marked last starts a drain
// of the stored values, one per cycle while the output does not stall, during which input
// is stalled; results come straight from the head cell of the chain.
// The first result shows in the cycle after the last request is accepted.
// Reset clears all valid flags, the overflow flag and the state; stored values are not reset.
`default_nettype none

module sorted_insertion_store (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  sis_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output sis_pkg::out_req_t  out_req_o
);
  import sis_pkg::*;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e     state_q, state_d;
  logic       overflow_q, overflow_d;
  cell_ctrl_t ctrl;
  cell_link_t link [StoreDepth];
  logic       full;
  logic       in_fire;
  logic       out_fire;
  logic       run_last;

  assign full     = link[StoreDepth-1].valid;
  assign run_last = link[0].valid && !link[1].valid;

  // Handshakes.
  assign in_stall_o  = (state_q != ST_FILL);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_DRAIN) && link[0].valid;
  assign out_fire    = out_valid_o && !out_stall_i;

  assign out_req_o.sorted_value = link[0].value;
  assign out_req_o.last_of_run  = run_last;
  assign out_req_o.overflow     = overflow_q;

  // Controller: insert while filling, shift toward the head while draining.
  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    ctrl.mode  = MODE_HOLD;
    ctrl.value = in_req_i.value;
    case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            ctrl.mode = MODE_INSERT;
          end
          if (in_req_i.last_value) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          ctrl.mode = MODE_SHIFT;
          if (run_last) begin
            state_d    = ST_FILL;
            overflow_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  // The chain of cells, head first.
  for (genvar i = 0; i < StoreDepth; i++) begin : g_cell
    cell_link_t left;
    cell_link_t right;

    if (i == 0) begin : g_head
      assign left = '{value: '0, valid: 1'b0, gt: 1'b1};
    end else begin : g_mid
      assign left = link[i-1];
    end

    if (i == StoreDepth - 1) begin : g_tail
      assign right = '{value: '0, valid: 1'b0, gt: 1'b0};
    end else begin : g_body
      assign right = link[i+1];
    end

    sis_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (link[i])
    );
  end

endmodule

`default_nettype wire

### dv/sorted_insertion_store_test.sv
`timescale 1ns / 100ps

// Keeps a shadow copy of the sorted store and the queue of drained values that
// the block still owes.
class sorted_run_scoreboard;
  logic signed [31:0] held_values[$];
  logic               drop_seen;
  sis_pkg::out_req_t  owed_results[$];
  int                 failures;

  function new();
    drop_seen = 1'b0;
    failures  = 0;
  endfunction

  // Print only the first few failures; count them all.
  function void report_failure(string msg);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Applies an accepted input request to the shadow store.
  function void note_request(sis_pkg::in_req_t req);
    logic signed [31:0] v;
    int                 pos;
    sis_pkg::out_req_t  res;
    v = req.value;
    if (held_values.size() >= sis_pkg::StoreDepth) begin
      drop_seen = 1'b1;
    end else begin
      // The new value goes ahead of any equal entries.
      pos = 0;
      while (pos < held_values.size() && v > held_values[pos]) pos++;
      held_values.insert(pos, v);
    end
    if (req.last_value) begin
      foreach (held_values[k]) begin
        res.sorted_value = held_values[k];
        res.last_of_run  = (k == held_values.size() - 1);
        res.overflow     = drop_seen;
        owed_results.push_back(res);
      end
      held_values.delete();
      drop_seen = 1'b0;
    end
  endfunction

  // Compares an accepted output request with the oldest owed result.
  function void check_result(sis_pkg::out_req_t got);
    sis_pkg::out_req_t want;
    if (owed_results.size() == 0) begin
      report_failure($sformatf("unexpected result: value %0d last %0b overflow %0b",
                               got.sorted_value, got.last_of_run, got.overflow));
      return;
    end
    want = owed_results.pop_front();
    if (got.sorted_value !== want.sorted_value || got.last_of_run !== want.last_of_run ||
        got.overflow !== want.overflow) begin
      report_failure($sformatf(
          "mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
          want.sorted_value, want.last_of_run, want.overflow,
          got.sorted_value, got.last_of_run, got.overflow));
    end
  endfunction

  // Anything still owed at the end counts as one failure.
  function int total_failures();
    if (owed_results.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", owed_results.size()));
    end
    return failures;
  endfunction
endclass

module sorted_insertion_store_test;
  import sis_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int HoldOffLen   = 150;
  localparam int ItemsPerPass = 60;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_off_start  = 1'b0;
  int hold_left       = 0;

  sorted_run_scoreboard sb = new();

  sorted_insertion_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one input request, with random idle cycles ahead of it, and waits
  // until the block takes it.
  task automatic send_request(logic signed [31:0] v, logic last);
    in_req_t req;
    req.value      = v;
    req.last_value = last;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '{value: $urandom, last_value: 1'($urandom_range(1))};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // Mixes full-range values, a narrow band that yields duplicates, and the
  // corner values of the signed range.
  function automatic logic signed [31:0] random_value();
    int narrow;
    narrow = $urandom_range(16);
    case ($urandom_range(3))
      0: return narrow - 8;
      1: begin
        case ($urandom_range(4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One set ends with the last mark; now and then it is long enough to
  // overflow the store.
  task automatic send_random_set(output int len);
    len = ($urandom_range(8) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      send_request(random_value(), i == len - 1);
    end
  endtask

  // Output side: random stall, long hold-off on request, and the check.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        hold_left      = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_req_o);
    end
  end

  // Main sequence: reset, directed sets, back-pressure, random phases.
  initial begin
    int sent;
    int len;
    int phase_idle[4];
    int phase_stall[4];
    phase_idle  = '{0, 66, 0, 30};
    phase_stall = '{0, 0, 66, 30};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-value sets at both ends of the range.
    send_request(32'sh7fff_ffff, 1'b1);
    send_request(32'sh8000_0000, 1'b1);

    // Corner values arriving out of order.
    send_request(0, 1'b0);
    send_request(32'sh7fff_ffff, 1'b0);
    send_request(-1, 1'b0);
    send_request(32'sh8000_0000, 1'b0);
    send_request(1, 1'b1);

    // Equal values.
    send_request(5, 1'b0);
    send_request(5, 1'b0);
    send_request(-3, 1'b0);
    send_request(5, 1'b0);
    send_request(-3, 1'b1);

    // Fill the store, then drop a plain value and a last-marked one.
    for (int i = 0; i < StoreDepth; i++) begin
      send_request((i % 2) ? 1000 - i : i - 1000, 1'b0);
    end
    send_request(7, 1'b0);
    send_request(32'sh8000_0000, 1'b1);

    // The overflow flag must be clear for the next set.
    send_request(42, 1'b1);

    // Back-pressure: the output holds off while sets keep coming, so the
    // drain stalls the input.
    hold_off_start = 1'b1;
    for (int i = 0; i < 5; i++) send_request(random_value(), i == 4);
    for (int i = 0; i < 8; i++) send_request(random_value(), i == 7);

    // Random sets under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = phase_idle[p];
      recv_stall_pct  = phase_stall[p];
      sent = 0;
      while (sent < ItemsPerPass) begin
        send_random_set(len);
        sent += len;
      end
    end
    in_valid_i <= 1'b0;

    // Let the last drain finish, then a few quiet cycles.
    recv_stall_pct = 0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (sb.total_failures() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
sv/sis_pkg.sv
sv/sis_cell.sv
sv/sorted_insertion_store.sv
dv/sorted_insertion_store_test.sv
